@@ src/mlp_relu_forward_pass_macros.svh @@
// Assertion macros for the network inference block.
// Taken in by the modules that carry concurrent checks; no other dependencies.
`ifndef MLP_RELU_FORWARD_PASS_MACROS_SVH
`define MLP_RELU_FORWARD_PASS_MACROS_SVH
`ifndef SYNTHESIS
`define MLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MLP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MLP_ASSERT(lbl, prop, msg)
`define MLP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ src/mlp_pkg.sv @@
// Shared types, constants and arithmetic helpers of the network inference block.
// No dependencies.
package mlp_pkg;

  localparam int MAX_LAYERS  = 4;
  localparam int MAX_NEURONS = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int ACC_W       = 2 * VALUE_WIDTH;

  localparam int LAYER_W  = $clog2(MAX_LAYERS);
  localparam int IDX_W    = $clog2(MAX_NEURONS);
  localparam int CNT_W    = IDX_W + 1;
  localparam int NL_W     = $clog2(MAX_LAYERS + 1);
  localparam int W_DEPTH  = MAX_LAYERS * MAX_NEURONS * MAX_NEURONS;
  localparam int B_DEPTH  = MAX_LAYERS * MAX_NEURONS;
  localparam int A_DEPTH  = 2 * MAX_NEURONS;
  localparam int W_ADDR_W = $clog2(W_DEPTH);
  localparam int B_ADDR_W = $clog2(B_DEPTH);
  localparam int A_ADDR_W = $clog2(A_DEPTH);

  localparam int NUM_REGS = 6;
  localparam int PADDR_W  = $clog2(NUM_REGS) + 2;

  // Register indexes.
  localparam logic [2:0] REG_LAYER_COUNT = 3'd0;
  localparam logic [2:0] REG_INPUT_WIDTH = 3'd1;
  localparam logic [2:0] REG_LAYER1      = 3'd2;
  localparam logic [2:0] REG_LAYER2      = 3'd3;
  localparam logic [2:0] REG_LAYER3      = 3'd4;
  localparam logic [2:0] REG_LAYER4      = 3'd5;

  // Item modes.
  localparam logic [1:0] MODE_WEIGHT = 2'd0;
  localparam logic [1:0] MODE_BIAS   = 2'd1;
  localparam logic [1:0] MODE_INPUT  = 2'd2;

  typedef struct packed {
    logic [1:0]                    mode;
    logic [1:0]                    layer_index;
    logic [5:0]                    target_index;
    logic [5:0]                    source_index;
    logic signed [VALUE_WIDTH-1:0] value;
  } mlp_in_t;

  typedef struct packed {
    logic [5:0]                    neuron_index;
    logic signed [VALUE_WIDTH-1:0] output_value;
    logic                          last_output;
  } mlp_out_t;

  // Saturated configuration seen by the controller.
  typedef struct packed {
    logic [NL_W-1:0]       nl;
    logic [4:0][CNT_W-1:0] w;   // w[0] input width, w[k] layer k width
  } mlp_cfg_t;

  typedef struct packed {
    logic                wr_weight;
    logic                wr_bias;
    logic                wr_act_in;
    logic                issue;
    logic                issue_last;
    logic                add_bias;
    logic                res_wr;
    logic                relu;
    logic                act_rd;
    logic                out_load;
    logic [W_ADDR_W-1:0] w_raddr;
    logic [B_ADDR_W-1:0] b_raddr;
    logic [A_ADDR_W-1:0] act_raddr;
    logic [A_ADDR_W-1:0] act_waddr;
  } mlp_cmd_t;

  typedef struct packed {
    logic mac_done;
  } mlp_stat_t;

  function automatic logic [CNT_W-1:0] sat_width(input logic [6:0] w);
    logic [CNT_W-1:0] r;
    if (w == 7'd0) begin
      r = CNT_W'(1);
    end else if (32'(w) > MAX_NEURONS) begin
      r = CNT_W'(MAX_NEURONS);
    end else begin
      r = CNT_W'(w);
    end
    return r;
  endfunction

  function automatic logic [NL_W-1:0] sat_layers(input logic [2:0] n);
    logic [NL_W-1:0] r;
    if (n == 3'd0) begin
      r = NL_W'(1);
    end else if (32'(n) > MAX_LAYERS) begin
      r = NL_W'(MAX_LAYERS);
    end else begin
      r = NL_W'(n);
    end
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W-1:0] s;
    s = a + b;
    if (!a[ACC_W-1] && !b[ACC_W-1] && s[ACC_W-1]) begin
      s = {1'b0, {(ACC_W-1){1'b1}}};
    end else if (a[ACC_W-1] && b[ACC_W-1] && !s[ACC_W-1]) begin
      s = {1'b1, {(ACC_W-1){1'b0}}};
    end
    return s;
  endfunction

  // Round to nearest (ties up) and saturate to the value range.
  function automatic logic signed [VALUE_WIDTH-1:0] round_sat(
      input logic signed [ACC_W-1:0] a);
    logic [ACC_W-FRAC_BITS:0] t;
    logic [VALUE_WIDTH-1:0]   r;
    t = {a[ACC_W-1], a[ACC_W-1:FRAC_BITS]}
        + {{(ACC_W-FRAC_BITS){1'b0}}, a[FRAC_BITS-1]};
    if (t[ACC_W-FRAC_BITS:VALUE_WIDTH-1] == '0
        || t[ACC_W-FRAC_BITS:VALUE_WIDTH-1] == '1) begin
      r = t[VALUE_WIDTH-1:0];
    end else if (t[ACC_W-FRAC_BITS]) begin
      r = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    end else begin
      r = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

@@ src/mlp_relu_forward_pass.sv @@
// Flow: a load item or non-final input element is taken while idle. The final input
// element starts a run over the layers, one MAC per cycle on the shared multiplier,
// then pipeline drain, bias and rounding per neuron; then output beats (read, load,
// hold while stalled). Throughput: one run at a time; input stalls until the last output
// beat is taken. Reset: registers read 1, controller idle, accumulator zero; the weight,
// bias and activation RAMs are not cleared.
// Top level; depends on mlp_pkg, mlp_ctrl, mlp_dp.
module mlp_relu_forward_pass (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mlp_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // Item input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mlp_pkg::mlp_in_t              in_data_i,
  // Result output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mlp_pkg::mlp_out_t             out_data_o
);

  logic [2:0]               layer_count_q;
  logic [4:0][6:0]          width_q;
  logic [2:0]               reg_idx;
  logic                     reg_wr;
  mlp_pkg::mlp_cfg_t        cfg;
  mlp_pkg::mlp_cmd_t        cmd;
  mlp_pkg::mlp_stat_t       stat;
  logic [5:0]               out_index;
  logic                     out_last;
  logic signed [31:0]       out_value;

  assign pready  = 1'b1;
  assign reg_idx = paddr[mlp_pkg::PADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_count_q <= 3'd1;
      width_q       <= {5{7'd1}};
    end else if (reg_wr) begin
      case (reg_idx)
        mlp_pkg::REG_LAYER_COUNT: layer_count_q <= pwdata[2:0];
        mlp_pkg::REG_INPUT_WIDTH: width_q[0]    <= pwdata[6:0];
        mlp_pkg::REG_LAYER1:      width_q[1]    <= pwdata[6:0];
        mlp_pkg::REG_LAYER2:      width_q[2]    <= pwdata[6:0];
        mlp_pkg::REG_LAYER3:      width_q[3]    <= pwdata[6:0];
        mlp_pkg::REG_LAYER4:      width_q[4]    <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mlp_pkg::REG_LAYER_COUNT: prdata = {29'd0, layer_count_q};
      mlp_pkg::REG_INPUT_WIDTH: prdata = {25'd0, width_q[0]};
      mlp_pkg::REG_LAYER1:      prdata = {25'd0, width_q[1]};
      mlp_pkg::REG_LAYER2:      prdata = {25'd0, width_q[2]};
      mlp_pkg::REG_LAYER3:      prdata = {25'd0, width_q[3]};
      mlp_pkg::REG_LAYER4:      prdata = {25'd0, width_q[4]};
      default:                  prdata = 32'd0;
    endcase
  end

  // Clamp widths and layer count once; the sequencer sees only legal values.
  always_comb begin
    cfg.nl = mlp_pkg::sat_layers(layer_count_q);
    for (int k = 0; k < 5; k++) begin
      cfg.w[k] = mlp_pkg::sat_width(width_q[k]);
    end
  end

  mlp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_index_o(out_index),
    .out_last_o (out_last),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  mlp_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_value_o(out_value)
  );

  assign out_data_o.neuron_index = out_index;
  assign out_data_o.output_value = out_value;
  assign out_data_o.last_output  = out_last;

endmodule

@@ src/mlp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mlp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/mlp_ctrl.sv @@
// Sequencer of the network inference block: loads, layer/neuron/source loops, output beats.
// Depends on mlp_pkg and mlp_relu_forward_pass_macros.svh.
`include "mlp_relu_forward_pass_macros.svh"
module mlp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mlp_pkg::mlp_cfg_t   cfg_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mlp_pkg::mlp_in_t    in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [5:0]          out_index_o,
  output logic                out_last_o,
  output mlp_pkg::mlp_cmd_t   cmd_o,
  input  mlp_pkg::mlp_stat_t  stat_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_FIN   = 3'd3;
  localparam logic [2:0] S_RND   = 3'd4;
  localparam logic [2:0] S_ORD   = 3'd5;
  localparam logic [2:0] S_OLD   = 3'd6;
  localparam logic [2:0] S_OHOLD = 3'd7;

  logic [2:0]                     state_q, state_d;
  logic [mlp_pkg::LAYER_W-1:0]    l_q, l_d;
  logic [mlp_pkg::IDX_W-1:0]      t_q, t_d;
  logic [mlp_pkg::IDX_W-1:0]      s_q, s_d;
  logic                           cur_q, cur_d;
  logic                           last_q, last_d;
  logic                           accept;
  logic [mlp_pkg::CNT_W-1:0]      sw, tw, ow;
  logic [mlp_pkg::NL_W-1:0]       l_next;
  logic                           s_end, t_end, o_end;

  assign accept = in_valid_i && !in_stall_o;
  assign l_next = mlp_pkg::NL_W'(l_q) + mlp_pkg::NL_W'(1);
  assign sw     = cfg_i.w[l_q];
  assign tw     = cfg_i.w[l_next];
  assign ow     = cfg_i.w[cfg_i.nl];
  assign s_end  = ({1'b0, s_q} == sw - mlp_pkg::CNT_W'(1));
  assign t_end  = ({1'b0, t_q} == tw - mlp_pkg::CNT_W'(1));
  assign o_end  = ({1'b0, t_q} == ow - mlp_pkg::CNT_W'(1));

  always_comb begin
    state_d = state_q;
    l_d     = l_q;
    t_d     = t_q;
    s_d     = s_q;
    cur_d   = cur_q;
    last_d  = last_q;
    cmd_o   = '0;
    cmd_o.w_raddr   = {l_q, t_q, s_q};
    cmd_o.b_raddr   = {l_q, t_q};
    cmd_o.act_raddr = {cur_q, s_q};
    cmd_o.act_waddr = {~cur_q, t_q};
    cmd_o.relu      = (l_next < cfg_i.nl);
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_data_i.mode)
            mlp_pkg::MODE_WEIGHT: cmd_o.wr_weight = 1'b1;
            mlp_pkg::MODE_BIAS:   cmd_o.wr_bias   = 1'b1;
            mlp_pkg::MODE_INPUT: begin
              cmd_o.wr_act_in = 1'b1;
              if ({1'b0, in_data_i.source_index} == cfg_i.w[0] - mlp_pkg::CNT_W'(1)) begin
                l_d     = '0;
                t_d     = '0;
                s_d     = '0;
                cur_d   = 1'b0;
                state_d = S_ISSUE;
              end
            end
            default: ;
          endcase
        end
      end
      S_ISSUE: begin
        cmd_o.issue      = 1'b1;
        cmd_o.issue_last = s_end;
        s_d = s_q + mlp_pkg::IDX_W'(1);
        if (s_end) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (stat_i.mac_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.add_bias = 1'b1;
        state_d = S_RND;
      end
      S_RND: begin
        cmd_o.res_wr = 1'b1;
        s_d = '0;
        if (t_end) begin
          t_d   = '0;
          cur_d = ~cur_q;
          if (l_next == cfg_i.nl) begin
            state_d = S_ORD;
          end else begin
            l_d     = l_q + mlp_pkg::LAYER_W'(1);
            state_d = S_ISSUE;
          end
        end else begin
          t_d     = t_q + mlp_pkg::IDX_W'(1);
          state_d = S_ISSUE;
        end
      end
      S_ORD: begin
        cmd_o.act_rd    = 1'b1;
        cmd_o.act_raddr = {cur_q, t_q};
        state_d = S_OLD;
      end
      S_OLD: begin
        cmd_o.out_load = 1'b1;
        last_d  = o_end;
        state_d = S_OHOLD;
      end
      S_OHOLD: begin
        if (!out_stall_i) begin
          if (last_q) begin
            state_d = S_IDLE;
          end else begin
            t_d     = t_q + mlp_pkg::IDX_W'(1);
            state_d = S_ORD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      l_q     <= '0;
      t_q     <= '0;
      s_q     <= '0;
      cur_q   <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      l_q     <= l_d;
      t_q     <= t_d;
      s_q     <= s_d;
      cur_q   <= cur_d;
      last_q  <= last_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OHOLD);
  assign out_index_o = t_q;
  assign out_last_o  = last_q;

  `MLP_ASSERT(a_src_in_range, state_q == S_ISSUE |-> {1'b0, s_q} < sw, "source past layer width")
  `MLP_ASSERT(a_mac_in_wait, stat_i.mac_done |-> state_q == S_WAIT, "mac done outside wait")
  `MLP_ASSERT(a_last_to_idle, (out_valid_o && !out_stall_i && last_q) |=> state_q == S_IDLE,
              "run did not end after last beat")

endmodule

@@ src/mlp_dp.sv @@
// Datapath: weight, bias and activation RAMs, multiplier, saturating accumulator, rounding.
// Depends on mlp_pkg and mlp_ram.
module mlp_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mlp_pkg::mlp_in_t                    in_data_i,
  input  mlp_pkg::mlp_cmd_t                   cmd_i,
  output mlp_pkg::mlp_stat_t                  stat_o,
  output logic signed [mlp_pkg::VALUE_WIDTH-1:0] out_value_o
);

  logic [mlp_pkg::VALUE_WIDTH-1:0]        w_rdata, b_rdata, a_rdata, a_wdata;
  logic [mlp_pkg::A_ADDR_W-1:0]           a_waddr;
  logic signed [mlp_pkg::ACC_W-1:0]       prod_q, acc_q, acc_d, bias_ext;
  logic signed [mlp_pkg::VALUE_WIDTH-1:0] res, out_q;
  logic                                   rd_v_q, rd_last_q, prod_v_q, prod_last_q;

  mlp_ram #(.WIDTH(mlp_pkg::VALUE_WIDTH), .DEPTH(mlp_pkg::W_DEPTH)) u_weight (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_weight),
    .waddr_i({in_data_i.layer_index, in_data_i.target_index, in_data_i.source_index}),
    .wdata_i(in_data_i.value),
    .re_i   (cmd_i.issue),
    .raddr_i(cmd_i.w_raddr),
    .rdata_o(w_rdata)
  );

  mlp_ram #(.WIDTH(mlp_pkg::VALUE_WIDTH), .DEPTH(mlp_pkg::B_DEPTH)) u_bias (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_bias),
    .waddr_i({in_data_i.layer_index, in_data_i.target_index}),
    .wdata_i(in_data_i.value),
    .re_i   (cmd_i.issue),
    .raddr_i(cmd_i.b_raddr),
    .rdata_o(b_rdata)
  );

  // Two activation banks: MSB of the address picks the bank.
  assign a_waddr = cmd_i.res_wr ? cmd_i.act_waddr : {1'b0, in_data_i.source_index};
  assign a_wdata = cmd_i.res_wr ? res : in_data_i.value;

  mlp_ram #(.WIDTH(mlp_pkg::VALUE_WIDTH), .DEPTH(mlp_pkg::A_DEPTH)) u_act (
    .clk_i  (clk_i),
    .we_i   (cmd_i.res_wr || cmd_i.wr_act_in),
    .waddr_i(a_waddr),
    .wdata_i(a_wdata),
    .re_i   (cmd_i.issue || cmd_i.act_rd),
    .raddr_i(cmd_i.act_raddr),
    .rdata_o(a_rdata)
  );

  assign bias_ext = {{(mlp_pkg::ACC_W-mlp_pkg::VALUE_WIDTH-mlp_pkg::FRAC_BITS){b_rdata[31]}},
                     b_rdata, {mlp_pkg::FRAC_BITS{1'b0}}};

  always_comb begin
    res = mlp_pkg::round_sat(acc_q);
    if (cmd_i.relu && res[mlp_pkg::VALUE_WIDTH-1]) begin
      res = '0;
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.res_wr) begin
      acc_d = '0;
    end else if (cmd_i.add_bias) begin
      acc_d = mlp_pkg::sat_add(acc_q, bias_ext);
    end else if (prod_v_q) begin
      acc_d = mlp_pkg::sat_add(acc_q, prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q      <= 1'b0;
      rd_last_q   <= 1'b0;
      prod_v_q    <= 1'b0;
      prod_last_q <= 1'b0;
      acc_q       <= '0;
    end else begin
      rd_v_q      <= cmd_i.issue;
      rd_last_q   <= cmd_i.issue_last;
      prod_v_q    <= rd_v_q;
      prod_last_q <= rd_v_q && rd_last_q;
      acc_q       <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_v_q) begin
      prod_q <= $signed(a_rdata) * $signed(w_rdata);
    end
    if (cmd_i.out_load) begin
      out_q <= a_rdata;
    end
  end

  assign stat_o.mac_done = prod_v_q && prod_last_q;
  assign out_value_o     = out_q;

endmodule
